### rtl/srle_pkg.sv
`timescale 1ns / 1ps

package srle_pkg;

  // Longest run, in pixels
  localparam logic [6:0] MAX_RUN   = 7'd127;
  // Row-end marker, also the transparent-run flag bit
  localparam logic [7:0] MARK_BYTE = 8'h80;

  // Which value the datapath drives onto the byte stream
  typedef enum logic [1:0] {
    SRC_TRANS = 2'd0,  // 0x80 | run length
    SRC_LEN   = 2'd1,  // opaque run length
    SRC_LIT   = 2'd2,  // buffered literal
    SRC_MARK  = 2'd3   // row-end marker
  } byte_src_t;

  // Controller -> datapath
  typedef struct packed {
    logic      load_in;     // capture the input beat
    logic      do_update;   // add the held pixel to the run
    logic      clear_run;   // row finished, no run open
    logic      byte_valid;  // a byte is offered to the packer
    logic      byte_final;  // it is the last byte of this pixel
    byte_src_t byte_src;
  } srle_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic close_run;          // open run must be closed before this pixel
    logic run_transparent;
    logic pixel_transparent;
    logic row_end;
    logic lit_last;           // literal index is at the end of the run
    logic byte_take;          // packer took the offered byte
  } srle_stat_t;

endpackage

### rtl/srle_ctrl.sv
`timescale 1ns / 1ps

module srle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  srle_pkg::srle_stat_t stat,
  output srle_pkg::srle_cmd_t  cmd
);
  import srle_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_TRANS  = 7'b0000100,
    ST_LEN    = 7'b0001000,
    ST_LIT    = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_MARK   = 7'b1000000
  } state_t;

  state_t state, state_next;
  // 0: closing the previous run, 1: closing the run at row end
  logic   phase, phase_next;
  state_t after_update;
  logic   phase_after;

  // Where to go once the pixel has joined its run
  always_comb begin
    phase_after  = phase;
    after_update = ST_IDLE;
    if (stat.row_end) begin
      if (stat.pixel_transparent) begin
        after_update = ST_MARK;
      end else begin
        after_update = ST_LEN;
        phase_after  = 1'b1;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.byte_src   = SRC_MARK;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.close_run) begin
          phase_next = 1'b0;
          state_next = stat.run_transparent ? ST_TRANS : ST_LEN;
        end else begin
          cmd.do_update = 1'b1;
          phase_next    = phase_after;
          state_next    = after_update;
        end
      end
      ST_TRANS: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_src   = SRC_TRANS;
        cmd.byte_final = !stat.row_end;
        if (stat.byte_take) state_next = ST_UPDATE;
      end
      ST_LEN: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_src   = SRC_LEN;
        if (stat.byte_take) state_next = ST_LIT;
      end
      ST_LIT: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_src   = SRC_LIT;
        cmd.byte_final = stat.lit_last && !phase && !stat.row_end;
        if (stat.byte_take && stat.lit_last) begin
          state_next = phase ? ST_MARK : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.do_update = 1'b1;
        phase_next    = phase_after;
        state_next    = after_update;
      end
      ST_MARK: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_src   = SRC_MARK;
        cmd.byte_final = 1'b1;
        if (stat.byte_take) begin
          cmd.clear_run = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

### rtl/srle_dp.sv
`timescale 1ns / 1ps

module srle_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           pixel,
  input  logic                 row_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           byte0,
  output logic [7:0]           byte1,
  output logic [7:0]           byte2,
  output logic [7:0]           byte3,
  output logic [2:0]           byte_count,
  output logic                 last,
  input  srle_pkg::srle_cmd_t  cmd,
  output srle_pkg::srle_stat_t stat
);
  import srle_pkg::*;

  // Held input beat
  logic [7:0] pixel_q;
  logic       row_end_q;
  logic       pix_tr;

  // Run state
  logic       run_open;
  logic       run_transparent;
  logic [6:0] run_length;
  logic       close_run;
  logic       new_run;
  logic [6:0] base;

  // Literal buffer, one write and one registered read port
  logic [7:0] lit_mem [128];
  logic [6:0] lit_idx, lit_idx_next;
  logic [7:0] lit_rd;

  // Byte stream and packer
  logic [7:0] byte_val;
  logic       byte_take;
  logic       word_done;
  logic [1:0] acc_cnt;
  logic [7:0] acc [3];
  logic [7:0] word [4];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pixel_q   <= pixel;
      row_end_q <= row_end;
    end
  end

  assign pix_tr    = (pixel_q == 8'd0);
  assign close_run = run_open &&
                     ((pix_tr != run_transparent) || (run_length == MAX_RUN));
  assign new_run   = !run_open || close_run;
  assign base      = new_run ? 7'd0 : run_length;

  // Run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open        <= 1'b0;
      run_transparent <= 1'b0;
      run_length      <= 7'd0;
    end else if (cmd.do_update) begin
      run_open        <= 1'b1;
      run_transparent <= pix_tr;
      run_length      <= 7'(base + 7'd1);
    end else if (cmd.clear_run) begin
      run_open   <= 1'b0;
      run_length <= 7'd0;
    end
  end

  // Literal write on an opaque pixel
  always_ff @(posedge clk) begin
    if (cmd.do_update && !pix_tr) begin
      lit_mem[base] <= pixel_q;
    end
  end

  // Read pointer: restart at the length byte, step on each literal taken
  always_comb begin
    lit_idx_next = lit_idx;
    if (cmd.byte_valid && cmd.byte_src == SRC_LEN) begin
      lit_idx_next = 7'd0;
    end else if (byte_take && cmd.byte_src == SRC_LIT) begin
      lit_idx_next = 7'(lit_idx + 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    lit_idx <= lit_idx_next;
    lit_rd  <= lit_mem[lit_idx_next];
  end

  // Byte source select
  always_comb begin
    unique case (cmd.byte_src)
      SRC_TRANS: byte_val = MARK_BYTE | {1'b0, run_length};
      SRC_LEN:   byte_val = {1'b0, run_length};
      SRC_LIT:   byte_val = lit_rd;
      SRC_MARK:  byte_val = MARK_BYTE;
      default:   byte_val = MARK_BYTE;
    endcase
  end

  assign byte_take = cmd.byte_valid && (!out_valid || out_ready);
  assign word_done = byte_take && ((acc_cnt == 2'd3) || cmd.byte_final);

  // Word being closed: held bytes, the new byte, zeros above
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < acc_cnt)       word[i] = acc[i];
      else if (2'(i) == acc_cnt) word[i] = byte_val;
      else                       word[i] = 8'd0;
    end
    word[3] = (acc_cnt == 2'd3) ? byte_val : 8'd0;
  end

  // Packer accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt <= 2'd0;
    end else if (word_done) begin
      acc_cnt <= 2'd0;
    end else if (byte_take) begin
      acc_cnt <= 2'(acc_cnt + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (byte_take && !word_done && acc_cnt == 2'(i)) acc[i] <= byte_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_done) begin
      byte0      <= word[0];
      byte1      <= word[1];
      byte2      <= word[2];
      byte3      <= word[3];
      byte_count <= 3'({1'b0, acc_cnt} + 3'd1);
      last       <= cmd.byte_final;
    end
  end

  always_comb begin
    stat.close_run         = close_run;
    stat.run_transparent   = run_transparent;
    stat.pixel_transparent = pix_tr;
    stat.row_end           = row_end_q;
    stat.lit_last          = (lit_idx == 7'(run_length - 7'd1));
    stat.byte_take         = byte_take;
  end

endmodule

### rtl/sprite_row_rle_encoder_unit.sv
`timescale 1ns / 1ps

// Sprite row run-length encoder. Takes one 8-bit palette pixel per input beat
// (0 is transparent) with a row-end flag and emits the encoded byte stream
// packed into words of up to four bytes; the last word caused by a pixel has
// last set, and a pixel that closes no run and ends no row gives no word.
// Flow: a pixel that produces no bytes is accepted, then decided and updated.
// The packer takes one byte per cycle while the output register can take a
// word, and the literal buffer has a single read port; closing a run before
// the new pixel adds an update step. Draining an opaque run sends its length
// byte and then its literals, so the worst pixel is a full opaque run closed,
// then a one-pixel opaque row tail. A full output word waits in an output
// register; the encoder keeps producing bytes while that register is empty
// or being taken in the same cycle.
module sprite_row_rle_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pixel,
  input  logic       row_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte0,
  output logic [7:0] byte1,
  output logic [7:0] byte2,
  output logic [7:0] byte3,
  output logic [2:0] byte_count,
  output logic       last
);
  import srle_pkg::*;

  srle_cmd_t  cmd;
  srle_stat_t stat;

  srle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srle_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .row_end    (row_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte0      (byte0),
    .byte1      (byte1),
    .byte2      (byte2),
    .byte3      (byte3),
    .byte_count (byte_count),
    .last       (last),
    .cmd        (cmd),
    .stat       (stat)
  );

  // No byte is offered while waiting for a pixel
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.byte_valid)
    else $error("byte offered while idle");

  // One pixel at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice back to back");

  // Word size in range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 3'd0 && byte_count <= 3'd4))
    else $error("byte_count out of range");

  // Unused byte lanes are zero in a one-byte word
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_count == 3'd1) |-> (byte1 == 8'd0 && byte2 == 8'd0 &&
                                           byte3 == 8'd0))
    else $error("unused byte lanes not zero");

endmodule

### verif/srle_stream_checker.sv
`timescale 1ns / 1ps

module srle_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] pixel,
  input  logic       row_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] byte0,
  input  logic [7:0] byte1,
  input  logic [7:0] byte2,
  input  logic [7:0] byte3,
  input  logic [2:0] byte_count,
  input  logic       last,
  output int         error_count,
  output int         words_pending
);
  import srle_pkg::*;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      count;
    logic            last;
  } enc_word_t;

  // Shadow of the encoder state
  logic       run_open;
  logic       run_clear;
  logic [6:0] run_len;
  logic [7:0] lit_mem [128];

  logic [7:0] step_bytes [$];
  enc_word_t  expected_words [$];
  enc_word_t  head;
  int         errs;

  // Close the open run; a transparent run at the end of a row is dropped
  function void close_open_run(input bit at_row_end);
    int i;
    if (!run_open) return;
    if (run_clear) begin
      if (!at_row_end) step_bytes.push_back(MARK_BYTE | {1'b0, run_len});
    end else begin
      step_bytes.push_back({1'b0, run_len});
      for (i = 0; i < run_len; i++) step_bytes.push_back(lit_mem[i]);
    end
    run_open = 1'b0;
    run_len  = '0;
  endfunction

  // Encode one pixel and queue the words it produces
  function void encode_pixel(input logic [7:0] px, input logic re);
    bit        clear_px;
    int        pos;
    int        cnt;
    int        j;
    enc_word_t w;
    clear_px = (px == 8'd0);
    step_bytes.delete();
    if (run_open && (clear_px != run_clear || run_len >= MAX_RUN)) close_open_run(1'b0);
    if (!run_open) begin
      run_open  = 1'b1;
      run_clear = clear_px;
      run_len   = '0;
    end
    if (!clear_px) lit_mem[run_len] = px;
    run_len = run_len + 7'd1;
    if (re) begin
      close_open_run(1'b1);
      step_bytes.push_back(MARK_BYTE);
    end
    // pack four bytes to a word, unused lanes zero
    for (pos = 0; pos < step_bytes.size(); pos += 4) begin
      cnt = step_bytes.size() - pos;
      if (cnt > 4) cnt = 4;
      w = '0;
      for (j = 0; j < cnt; j++) w.data[j] = step_bytes[pos + j];
      w.count = cnt[2:0];
      w.last  = (pos + 4 >= step_bytes.size());
      expected_words.push_back(w);
    end
  endfunction

  function void check_field(input string name, input int unsigned exp_v,
                            input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errs++;
    end
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    if (rst) begin
      run_open  = 1'b0;
      run_clear = 1'b0;
      run_len   = '0;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) encode_pixel(pixel, row_end);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output beat: byte0=0x%0h byte_count=%0d", byte0, byte_count);
          errs++;
        end else begin
          head = expected_words.pop_front();
          check_field("byte0", 32'(head.data[0]), 32'(byte0));
          check_field("byte1", 32'(head.data[1]), 32'(byte1));
          check_field("byte2", 32'(head.data[2]), 32'(byte2));
          check_field("byte3", 32'(head.data[3]), 32'(byte3));
          check_field("byte_count", 32'(head.count), 32'(byte_count));
          check_field("last", 32'(head.last), 32'(last));
        end
      end
    end
    error_count   <= errs;
    words_pending <= expected_words.size();
  end

endmodule

### verif/sprite_row_rle_encoder_unit_test.sv
`timescale 1ns / 1ps

module sprite_row_rle_encoder_unit_test;

  localparam int RANDOM_ITEMS = 350;
  localparam int DIRECTED_ITEMS = 18;
  localparam int TOTAL_ITEMS = DIRECTED_ITEMS + RANDOM_ITEMS;
  localparam int QUIET_FROM = TOTAL_ITEMS - 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 160;

  typedef enum int {MIX_CLEAR, MIX_OPAQUE, MIX_ANY} row_mix_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] pixel = 8'd0;
  logic       row_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [2:0] byte_count;
  logic       last;

  int error_count;
  int words_pending;
  int cycles = 0;
  int sent = 0;
  int stall_left = 0;
  int stall_odds = 4;
  int row_len;
  int row_odds;
  bit in_idle_on = 1'b1;
  bit quiet = 1'b0;

  sprite_row_rle_encoder_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .row_end    (row_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte0      (byte0),
    .byte1      (byte1),
    .byte2      (byte2),
    .byte3      (byte3),
    .byte_count (byte_count),
    .last       (last)
  );

  srle_stream_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel         (pixel),
    .row_end       (row_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte0         (byte0),
    .byte1         (byte1),
    .byte2         (byte2),
    .byte3         (byte3),
    .byte_count    (byte_count),
    .last          (last),
    .error_count   (error_count),
    .words_pending (words_pending)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output back-pressure in bursts; the stall odds are redrawn from three settings, one with no random stalls
  always @(posedge clk) begin
    if (cycles % 256 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_odds <= 0;
        1: stall_odds <= 3;
        default: stall_odds <= 8;
      endcase
    end
    if (rst || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One input beat, with an optional idle burst ahead of it
  task automatic push_pixel(input logic [7:0] px, input logic re);
    int gap;
    if (sent == QUIET_FROM) quiet <= 1'b1;
    if (sent < QUIET_FROM && in_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= px;
    row_end  <= re;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // A row of len pixels; switch_odds 0 keeps one pixel kind for the whole row
  task automatic random_row(input int len, input row_mix_t mix, input int switch_odds);
    logic [7:0] px;
    bit         opaque;
    int         i;
    case (mix)
      MIX_CLEAR:  opaque = 1'b0;
      MIX_OPAQUE: opaque = 1'b1;
      default:    opaque = 1'($urandom_range(0, 1));
    endcase
    in_idle_on = ($urandom_range(0, 2) != 0);
    for (i = 0; i < len; i++) begin
      if (switch_odds != 0 && $urandom_range(1, switch_odds) == 1) opaque = !opaque;
      case ($urandom_range(0, 7))
        0: px = 8'hff;
        1: px = 8'h01;
        default: px = 8'($urandom_range(1, 255));
      endcase
      if (!opaque) px = 8'd0;
      push_pixel(px, i == len - 1);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single-pixel rows: transparent, then opaque at the top value
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hff, 1'b1);
    // transparent run closed mid-row, then an opaque run closed by a transparent pixel
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'hff, 1'b0);
    push_pixel(8'h00, 1'b0);
    // trailing transparent run dropped at row end
    push_pixel(8'h00, 1'b1);
    push_pixel(8'h07, 1'b0);
    push_pixel(8'h09, 1'b0);
    push_pixel(8'h00, 1'b1);
    // exactly one full word, then a row spilling into a second word
    push_pixel(8'h00, 1'b0);
    push_pixel(8'haa, 1'b1);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'h55, 1'b1);

    // full opaque run closed by an opaque row tail: the longest burst of words
    random_row(128, MIX_OPAQUE, 0);
    // full transparent run closed mid-row
    random_row(128, MIX_CLEAR, 0);
    // random rows, the last one cut short to land on the item total
    while (sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        row_len  = $urandom_range(100, 140);
        row_odds = 48;
      end else begin
        row_len  = $urandom_range(1, 16);
        row_odds = 3;
      end
      if (row_len > TOTAL_ITEMS - sent) row_len = TOTAL_ITEMS - sent;
      random_row(row_len, MIX_ANY, row_odds);
    end
    in_valid <= 1'b0;

    // drain, then allow for stray words
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
